// ===== src/lpps_pkg.sv =====
package lpps_pkg;

  localparam int ADC_BITS  = 12;
  localparam int DUTY_BITS = 10;
  localparam int NSENS     = 5;
  localparam int IDX_W     = 3;
  localparam int NORM_W    = 16;
  localparam int DIV_W     = 34;
  localparam int STEP_W    = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 18;
  localparam int ERR_W     = 17;
  localparam int SUM_W     = 19;
  localparam int GAIN_W    = 16;
  localparam int LIM_W     = 18;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_CAL   = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_RUN   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LVL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_LVL  = 3'd7;

  localparam logic [DUTY_BITS-1:0] SPIN_DUTY = DUTY_BITS'(450);

  typedef struct packed {
    logic             load;
    logic             norm_set;
    logic             div_step;
    logic             norm_store;
    logic             err_calc;
    logic             err_set;
    logic             err_store;
    logic             mul_step;
    logic [1:0]       msel;
    logic             finish;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic run_sample;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/lpps_if.sv =====
interface lpps_in_if;
  import lpps_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [ADC_BITS-1:0] sensor0;
  logic [ADC_BITS-1:0] sensor1;
  logic [ADC_BITS-1:0] sensor2;
  logic [ADC_BITS-1:0] sensor3;
  logic [ADC_BITS-1:0] sensor4;
  modport source (output valid, opcode, sensor0, sensor1, sensor2, sensor3, sensor4,
                  input ready);
  modport sink (input valid, opcode, sensor0, sensor1, sensor2, sensor3, sensor4,
                output ready);
endinterface

interface lpps_out_if;
  import lpps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DUTY_BITS-1:0] left_duty;
  logic [DUTY_BITS-1:0] right_duty;
  logic                 is_running;
  logic                 stop_seen;
  logic                 line_lost;
  logic signed [ERR_W-1:0] line_error;
  modport source (output valid, left_duty, right_duty, is_running, stop_seen, line_lost,
                  line_error, input ready);
  modport sink (input valid, left_duty, right_duty, is_running, stop_seen, line_lost,
                line_error, output ready);
endinterface

// ===== src/line_position_pid_steering.sv =====
// Processing: a run sample in run mode passes through the shared restoring divider, which
// takes 16 steps for each of five sensors and the error, and then through the
// multiply-accumulate steps. Other frames go straight from decode to the finish state.
// Throughput: one frame is in work at a time; the next beat is taken only after the result
// enters the output register, and a stalled output holds the frame in its finish state.
// Reset (rst, synchronous, active high) restores gains, levels, calibration and PID state.
module line_position_pid_steering (
  input  logic                           clk,
  input  logic                           rst,
  lpps_in_if.sink                        in_ch,
  lpps_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [lpps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lpps_pkg::CFG_DAT_W-1:0] cfg_data
);
  import lpps_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lpps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lpps_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== src/lpps_ctrl.sv =====
module lpps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lpps_pkg::dp_status_t status,
  output lpps_pkg::dp_cmd_t    cmd
);
  import lpps_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_NSET   = 4'd2;
  localparam logic [3:0] S_NDIV   = 4'd3;
  localparam logic [3:0] S_NSTORE = 4'd4;
  localparam logic [3:0] S_ECALC  = 4'd5;
  localparam logic [3:0] S_ESET   = 4'd6;
  localparam logic [3:0] S_EDIV   = 4'd7;
  localparam logic [3:0] S_ESTORE = 4'd8;
  localparam logic [3:0] S_MUL    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0]        state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [STEP_W-1:0] step, step_next;
  logic [1:0]        msel, msel_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    step_next  = step;
    msel_next  = msel;
    cmd        = '0;
    cmd.idx    = idx;
    cmd.msel   = msel;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        idx_next   = '0;
        state_next = status.run_sample ? S_NSET : S_FIN;
      end
      S_NSET: begin
        cmd.norm_set = 1'b1;
        step_next    = '0;
        state_next   = S_NDIV;
      end
      S_NDIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == '1) state_next = S_NSTORE;
      end
      S_NSTORE: begin
        cmd.norm_store = 1'b1;
        if (idx == IDX_W'(NSENS - 1)) begin
          state_next = S_ECALC;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_NSET;
        end
      end
      S_ECALC: begin
        cmd.err_calc = 1'b1;
        state_next   = S_ESET;
      end
      S_ESET: begin
        cmd.err_set = 1'b1;
        step_next   = '0;
        state_next  = S_EDIV;
      end
      S_EDIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == '1) state_next = S_ESTORE;
      end
      S_ESTORE: begin
        cmd.err_store = 1'b1;
        msel_next     = '0;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        msel_next    = msel + 1'b1;
        if (msel == 2'd3) state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      step  <= '0;
      msel  <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      step  <= step_next;
      msel  <= msel_next;
    end
  end

  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free) else $error("finish without free output");
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_NDIV && step == '1) |=> (state == S_NSTORE))
    else $error("normalize division did not end");
  a_load_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_DECODE && !in_ready)) else $error("load not followed by decode");

endmodule

// ===== src/lpps_datapath.sv =====
module lpps_datapath (
  input  logic                               clk,
  input  logic                               rst,
  lpps_in_if.sink                            in_ch,
  lpps_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [lpps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpps_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  lpps_pkg::dp_cmd_t                  cmd,
  output lpps_pkg::dp_status_t               status
);
  import lpps_pkg::*;

  logic signed [GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic [DUTY_BITS-1:0]     base_duty, max_duty;
  logic [LIM_W-1:0]         int_limit;
  logic [NORM_W-1:0]        stop_lvl, lost_lvl;

  logic [1:0]               op_q;
  logic [ADC_BITS-1:0]      s_q [NSENS];
  logic [ADC_BITS-1:0]      cal_low [NSENS];
  logic [ADC_BITS-1:0]      cal_high [NSENS];
  logic [NORM_W-1:0]        n_q [NSENS];

  logic [DIV_W-1:0]         dvd, dvs;
  logic [NORM_W-1:0]        quo;
  logic                     nzero, nsat;

  logic [DIV_W-1:0]         scaled_q;
  logic [SUM_W-1:0]         den_q;
  logic                     numneg_q, lost_q, stop_q, upd_q;

  logic signed [ERR_W-1:0]  err_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [ERR_W:0]    deriv_q;
  logic signed [34:0]       prod_q;
  logic signed [36:0]       acc_q;

  logic                     run_flag, lost_flag;
  logic [DUTY_BITS-1:0]     held_left, held_right;
  logic signed [SUM_W-1:0]  error_sum;
  logic signed [ERR_W-1:0]  last_error;

  logic                     out_valid;

  assign status.run_sample = (op_q == OP_RUN) && run_flag;
  assign status.out_free   = !out_valid || out_ch.ready;
  assign out_ch.valid      = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= 16'sd256;
      gain_i    <= 16'sd0;
      gain_d    <= 16'sd179;
      base_duty <= DUTY_BITS'(500);
      max_duty  <= DUTY_BITS'(799);
      int_limit <= LIM_W'(128000);
      stop_lvl  <= NORM_W'(39322);
      lost_lvl  <= NORM_W'(19661);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_P:    gain_p    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:    gain_i    <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:    gain_d    <= cfg_data[GAIN_W-1:0];
        REG_BASE_DUTY: base_duty <= cfg_data[DUTY_BITS-1:0];
        REG_MAX_DUTY:  max_duty  <= cfg_data[DUTY_BITS-1:0];
        REG_INT_LIMIT: int_limit <= cfg_data[LIM_W-1:0];
        REG_STOP_LVL:  stop_lvl  <= cfg_data[NORM_W-1:0];
        REG_LOST_LVL:  lost_lvl  <= cfg_data[NORM_W-1:0];
        default: ;
      endcase
    end
  end

  logic [ADC_BITS-1:0] cur_s, cur_lo, cur_hi, cur_d, cur_rng;
  always_comb begin
    cur_s   = s_q[cmd.idx];
    cur_lo  = cal_low[cmd.idx];
    cur_hi  = cal_high[cmd.idx];
    cur_d   = cur_s - cur_lo;
    cur_rng = cur_hi - cur_lo;
  end

  logic               div_ge;
  assign div_ge = (dvd >= dvs);

  logic signed [19:0] num_c;
  logic [SUM_W-1:0]   den_c;
  logic [SUM_W-1:0]   mag_c;
  logic [25:0]        mag100_c;
  logic               lost_c, stop_c;
  always_comb begin
    num_c = -(20'sd2 * $signed({4'b0, n_q[0]})) - $signed({4'b0, n_q[1]})
            + $signed({4'b0, n_q[3]}) + 20'sd2 * $signed({4'b0, n_q[4]});
    den_c = SUM_W'(n_q[0]) + SUM_W'(n_q[1]) + SUM_W'(n_q[2]) + SUM_W'(n_q[3])
            + SUM_W'(n_q[4]);
    mag_c = num_c[19] ? SUM_W'(-num_c) : SUM_W'(num_c);
    mag100_c = {mag_c, 6'b0} + {1'b0, mag_c, 5'b0} + {5'b0, mag_c, 2'b0};
    lost_c = 1'b1;
    for (int i = 0; i < NSENS; i++) begin
      if (n_q[i] >= lost_lvl) lost_c = 1'b0;
    end
    stop_c = (n_q[0] > stop_lvl) && (n_q[1] > stop_lvl) && (n_q[3] > stop_lvl)
             && (n_q[4] > stop_lvl);
  end

  logic signed [ERR_W-1:0] err_c;
  logic signed [SUM_W:0]   sum_raw, lim_s;
  logic signed [SUM_W-1:0] sum_c;
  always_comb begin
    if (den_q == '0) err_c = '0;
    else if (numneg_q) err_c = -$signed({1'b0, quo});
    else err_c = $signed({1'b0, quo});
    sum_raw = $signed({error_sum[SUM_W-1], error_sum}) + (SUM_W+1)'(err_c);
    lim_s   = $signed({2'b0, int_limit});
    if (sum_raw > lim_s) sum_c = SUM_W'(lim_s);
    else if (sum_raw < -lim_s) sum_c = SUM_W'(-lim_s);
    else sum_c = SUM_W'(sum_raw);
  end

  logic signed [GAIN_W-1:0] mul_a;
  logic signed [SUM_W-1:0]  mul_b;
  always_comb begin
    case (cmd.msel)
      2'd0:    begin mul_a = gain_p; mul_b = SUM_W'(err_q);   end
      2'd1:    begin mul_a = gain_i; mul_b = sum_q;           end
      default: begin mul_a = gain_d; mul_b = SUM_W'(deriv_q); end
    endcase
  end

  function automatic logic [DUTY_BITS-1:0] clamp_duty(input logic signed [22:0] v,
                                                     input logic [DUTY_BITS-1:0] mx);
    if (v > $signed({7'b0, mx})) clamp_duty = mx;
    else if (v < 0) clamp_duty = '0;
    else clamp_duty = v[DUTY_BITS-1:0];
  endfunction

  logic signed [20:0]      pid_out;
  logic signed [22:0]      base_s;
  logic [DUTY_BITS-1:0]    pid_l, pid_r;
  logic                    run_n, lost_n, stop_o;
  logic [DUTY_BITS-1:0]    hl_n, hr_n, ol, orr;
  logic signed [SUM_W-1:0] es_n;
  logic signed [ERR_W-1:0] le_n;
  always_comb begin
    pid_out = acc_q[36:16];
    base_s  = $signed({7'b0, base_duty});
    pid_l   = clamp_duty(base_s - 23'(pid_out), max_duty);
    pid_r   = clamp_duty(base_s + 23'(pid_out), max_duty);
    run_n  = run_flag;
    lost_n = lost_flag;
    hl_n   = held_left;
    hr_n   = held_right;
    es_n   = error_sum;
    le_n   = last_error;
    stop_o = 1'b0;
    ol     = '0;
    orr    = '0;
    case (op_q) inside
      OP_CLEAR, OP_CAL: begin
        run_n  = 1'b0;
        lost_n = 1'b0;
        hl_n   = '0;
        hr_n   = '0;
        if (op_q == OP_CAL) begin
          ol  = SPIN_DUTY;
          orr = SPIN_DUTY;
        end
      end
      OP_START: begin
        run_n  = 1'b1;
        lost_n = 1'b0;
        ol     = held_left;
        orr    = held_right;
      end
      default: begin
        if (run_flag && upd_q) begin
          es_n = sum_q;
          le_n = err_q;
          hl_n = pid_l;
          hr_n = pid_r;
          if (stop_q) begin
            run_n  = 1'b0;
            lost_n = 1'b0;
            hl_n   = '0;
            hr_n   = '0;
            stop_o = 1'b1;
          end else if (lost_q) begin
            lost_n = 1'b1;
            if (err_q > 0) hl_n = '0;
            else hr_n = '0;
          end else begin
            lost_n = 1'b0;
          end
        end
        ol  = hl_n;
        orr = hr_n;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= in_ch.opcode;
      s_q[0] <= in_ch.sensor0;
      s_q[1] <= in_ch.sensor1;
      s_q[2] <= in_ch.sensor2;
      s_q[3] <= in_ch.sensor3;
      s_q[4] <= in_ch.sensor4;
    end
    if (cmd.norm_set) begin
      dvd   <= DIV_W'({cur_d, 16'b0});
      dvs   <= DIV_W'({cur_rng, 15'b0});
      quo   <= '0;
      nzero <= (cur_hi <= cur_lo) || (cur_s <= cur_lo);
      nsat  <= (cur_d >= cur_rng);
    end
    if (cmd.err_set) begin
      dvd <= scaled_q;
      dvs <= DIV_W'({den_q, 15'b0});
      quo <= '0;
    end
    if (cmd.div_step) begin
      if (div_ge) dvd <= dvd - dvs;
      quo <= {quo[NORM_W-2:0], div_ge};
      dvs <= dvs >> 1;
    end
    if (cmd.norm_store) begin
      n_q[cmd.idx] <= nzero ? '0 : (nsat ? '1 : quo);
    end
    if (cmd.err_calc) begin
      scaled_q <= {mag100_c, 8'b0};
      den_q    <= den_c;
      numneg_q <= num_c[19];
      lost_q   <= lost_c;
      stop_q   <= stop_c;
      upd_q    <= !(lost_flag && lost_c);
    end
    if (cmd.err_store) begin
      err_q   <= err_c;
      sum_q   <= sum_c;
      deriv_q <= $signed({err_c[ERR_W-1], err_c}) - $signed({last_error[ERR_W-1], last_error});
    end
    if (cmd.mul_step) begin
      prod_q <= mul_a * mul_b;
      acc_q  <= (cmd.msel == 2'd0) ? '0 : acc_q + 37'(prod_q);
    end
    if (cmd.finish) begin
      out_ch.left_duty  <= ol;
      out_ch.right_duty <= orr;
      out_ch.is_running <= run_n;
      out_ch.stop_seen  <= stop_o;
      out_ch.line_lost  <= (op_q == OP_RUN) && run_flag && lost_n;
      out_ch.line_error <= le_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSENS; i++) begin
        cal_low[i]  <= '1;
        cal_high[i] <= '0;
      end
      run_flag   <= 1'b0;
      lost_flag  <= 1'b0;
      held_left  <= '0;
      held_right <= '0;
      error_sum  <= '0;
      last_error <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        run_flag   <= run_n;
        lost_flag  <= lost_n;
        held_left  <= hl_n;
        held_right <= hr_n;
        error_sum  <= es_n;
        last_error <= le_n;
        if (op_q == OP_CLEAR) begin
          for (int i = 0; i < NSENS; i++) begin
            cal_low[i]  <= '1;
            cal_high[i] <= '0;
          end
        end else if (op_q == OP_CAL) begin
          for (int i = 0; i < NSENS; i++) begin
            if (s_q[i] < cal_low[i]) cal_low[i] <= s_q[i];
            if (s_q[i] > cal_high[i]) cal_high[i] <= s_q[i];
          end
        end
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_fin_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid) else $error("result beat lost");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !cmd.finish) else $error("result overwritten");
  a_stop_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && stop_o) |=> (!run_flag && held_left == '0 && held_right == '0))
    else $error("stop line did not end run");

endmodule

// ===== test/tb_line_position_pid_steering.sv =====
`timescale 1ns / 100ps

class steering_scoreboard;
  typedef struct packed {
    logic [9:0]  left;
    logic [9:0]  right;
    logic        running;
    logic        stop;
    logic        lost;
    logic [16:0] err;
  } steer_result_t;

  int signed gp, gi, gd;
  int unsigned base, maxd, ilim, stop_lvl, lost_lvl;
  int unsigned lo[5], hi[5];
  longint signed esum, lerr;
  bit run, lostf;
  int unsigned hl, hr;
  steer_result_t pending[$];
  int mismatches;

  function new();
    gp = 256; gi = 0; gd = 179;
    base = 500; maxd = 799; ilim = 128000; stop_lvl = 39322; lost_lvl = 19661;
    clear_cal();
    esum = 0; lerr = 0; run = 0; lostf = 0; hl = 0; hr = 0;
    mismatches = 0;
  endfunction

  function void clear_cal();
    for (int i = 0; i < 5; i++) begin
      lo[i] = 4095;
      hi[i] = 0;
    end
  endfunction

  function void write_reg(int idx, logic [17:0] v);
    case (idx)
      0: gp = $signed(v[15:0]);
      1: gi = $signed(v[15:0]);
      2: gd = $signed(v[15:0]);
      3: base = v[9:0];
      4: maxd = v[9:0];
      5: ilim = v[17:0];
      6: stop_lvl = v[15:0];
      7: lost_lvl = v[15:0];
      default: ;
    endcase
  endfunction

  function int unsigned norm_sensor(int unsigned s, int i);
    longint unsigned q;
    if (hi[i] <= lo[i] || s <= lo[i]) return 0;
    q = (longint'(s - lo[i]) << 16) / (hi[i] - lo[i]);
    return (q > 65535) ? 65535 : 32'(q);
  endfunction

  function int unsigned clamp_duty(longint signed v);
    if (v > longint'(maxd)) v = longint'(maxd);
    if (v < 0) v = 0;
    return 32'(v);
  endfunction

  function void steer(int unsigned n[5]);
    longint signed num, den, e, s, acc, o;
    num = -2 * longint'(n[0]) - n[1] + n[3] + 2 * longint'(n[4]);
    den = longint'(n[0]) + n[1] + n[2] + n[3] + n[4];
    e = (den != 0) ? (num * 25600) / den : 0;
    s = esum + e;
    if (s > longint'(ilim)) s = longint'(ilim);
    if (s < -longint'(ilim)) s = -longint'(ilim);
    acc = gp * e + gi * s + gd * (e - lerr);
    o = (acc >= 0) ? acc / 65536 : -((-acc + 65535) / 65536);
    hl = clamp_duty(longint'(base) - o);
    hr = clamp_duty(longint'(base) + o);
    esum = s;
    lerr = e;
  endfunction

  function void note_frame(logic [1:0] op, logic [11:0] sv[5]);
    steer_result_t r;
    int unsigned n[5];
    bit lost, stop, lost_out;
    int unsigned l, rt;
    stop = 0; lost_out = 0; l = 0; rt = 0;
    if (op == lpps_pkg::OP_CLEAR || op == lpps_pkg::OP_CAL) begin
      run = 0; lostf = 0; hl = 0; hr = 0;
      if (op == lpps_pkg::OP_CLEAR) begin
        clear_cal();
      end else begin
        for (int i = 0; i < 5; i++) begin
          if (sv[i] < lo[i]) lo[i] = sv[i];
          if (sv[i] > hi[i]) hi[i] = sv[i];
        end
        l = 450; rt = 450;
      end
    end else if (op == lpps_pkg::OP_START) begin
      run = 1; lostf = 0; l = hl; rt = hr;
    end else begin
      if (run) begin
        lost = 1;
        for (int i = 0; i < 5; i++) begin
          n[i] = norm_sensor(sv[i], i);
          if (n[i] >= lost_lvl) lost = 0;
        end
        stop = n[0] > stop_lvl && n[1] > stop_lvl && n[3] > stop_lvl && n[4] > stop_lvl;
        if (!(lostf && lost)) begin
          steer(n);
          if (stop) begin
            run = 0; lostf = 0; hl = 0; hr = 0;
          end else if (lost) begin
            lostf = 1;
            if (lerr > 0) hl = 0;
            else hr = 0;
          end else begin
            lostf = 0;
          end
        end else begin
          stop = 0;
        end
        lost_out = lostf;
      end
      l = hl; rt = hr;
    end
    r.left = 10'(l); r.right = 10'(rt); r.running = run; r.stop = stop; r.lost = lost_out;
    r.err = lerr[16:0];
    pending.push_back(r);
  endfunction

  function void check_result(steer_result_t got);
    steer_result_t w;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat");
      return;
    end
    w = pending.pop_front();
    if (got !== w) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch: exp l=%0d r=%0d run=%0b stop=%0b lost=%0b err=%0d",
                  " got l=%0d r=%0d run=%0b stop=%0b lost=%0b err=%0d"},
                 w.left, w.right, w.running, w.stop, w.lost, $signed(w.err),
                 got.left, got.right, got.running, got.stop, got.lost, $signed(got.err));
    end
  endfunction
endclass

module tb_line_position_pid_steering;
  import lpps_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  lpps_in_if in_ch();
  lpps_out_if out_ch();

  steering_scoreboard sb = new();
  int cycles = 0;
  int hold_off = 0;
  bit stalls_on = 1;

  line_position_pid_steering i_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = '0;
    in_ch.sensor0 = '0; in_ch.sensor1 = '0; in_ch.sensor2 = '0;
    in_ch.sensor3 = '0; in_ch.sensor4 = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.left_duty, out_ch.right_duty, out_ch.is_running,
                        out_ch.stop_seen, out_ch.line_lost, out_ch.line_error});
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ch.ready <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (stalls_on && $urandom_range(0, 1)) begin
        hold_off <= $urandom_range(0, 7);
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= 1;
      end
    end else begin
      out_ch.ready <= 1;
    end
  end

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_frame(logic [1:0] op, logic [11:0] s0, logic [11:0] s1,
                            logic [11:0] s2, logic [11:0] s3, logic [11:0] s4);
    logic [11:0] sv[5];
    int gap;
    gap = stalls_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    sv = '{s0, s1, s2, s3, s4};
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.sensor0 <= s0; in_ch.sensor1 <= s1; in_ch.sensor2 <= s2;
    in_ch.sensor3 <= s3; in_ch.sensor4 <= s4;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_frame(op, sv);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic rand_frame(int unsigned pick);
    logic [1:0] op;
    logic [11:0] s[5];
    for (int i = 0; i < 5; i++) s[i] = 12'($urandom_range(0, 4095));
    if (pick < 4) op = OP_CLEAR;
    else if (pick < 14) op = OP_CAL;
    else if (pick < 22) op = OP_START;
    else op = OP_RUN;
    if (op == OP_RUN && $urandom_range(0, 9) == 0)
      for (int i = 0; i < 5; i++) s[i] = 12'($urandom_range(0, 300));
    if (op == OP_RUN && $urandom_range(0, 19) == 0)
      for (int i = 0; i < 5; i++) s[i] = (i == 2) ? 12'($urandom_range(0, 4095)) : 12'(4095);
    send_frame(op, s[0], s[1], s[2], s[3], s[4]);
  endtask

  task automatic run_phase(int count);
    send_frame(OP_CLEAR, 0, 0, 0, 0, 0);
    for (int k = 0; k < 3; k++)
      send_frame(OP_CAL, 12'($urandom_range(0, 400)), 12'($urandom_range(0, 400)),
                 12'($urandom_range(0, 400)), 12'($urandom_range(0, 400)),
                 12'($urandom_range(0, 400)));
    for (int k = 0; k < 3; k++)
      send_frame(OP_CAL, 12'($urandom_range(3600, 4095)), 12'($urandom_range(3600, 4095)),
                 12'($urandom_range(3600, 4095)), 12'($urandom_range(3600, 4095)),
                 12'($urandom_range(3600, 4095)));
    send_frame(OP_START, 0, 0, 0, 0, 0);
    for (int k = 0; k < count; k++)
      rand_frame($urandom_range(0, 99) < 92 ? 22 : $urandom_range(0, 21));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_frame(OP_RUN, 4095, 4095, 4095, 4095, 4095);
    send_frame(OP_START, 0, 0, 0, 0, 0);
    send_frame(OP_RUN, 100, 200, 300, 400, 500);
    send_frame(OP_CAL, 0, 0, 0, 0, 0);
    send_frame(OP_CAL, 4095, 4095, 4095, 4095, 4095);
    send_frame(OP_START, 0, 0, 0, 0, 0);
    send_frame(OP_START, 0, 0, 0, 0, 0);
    send_frame(OP_RUN, 2048, 2048, 2048, 2048, 2048);
    send_frame(OP_RUN, 4095, 0, 0, 0, 0);
    send_frame(OP_RUN, 0, 0, 0, 0, 4095);
    send_frame(OP_RUN, 0, 0, 0, 0, 0);
    send_frame(OP_RUN, 0, 0, 0, 0, 0);
    send_frame(OP_RUN, 0, 0, 4095, 0, 0);
    send_frame(OP_RUN, 4095, 4095, 0, 4095, 4095);
    send_frame(OP_RUN, 1000, 1000, 1000, 1000, 1000);
    send_frame(OP_START, 0, 0, 0, 0, 0);
    send_frame(OP_RUN, 0, 0, 0, 0, 0);
    send_frame(OP_CAL, 2000, 2000, 2000, 2000, 2000);
    send_frame(OP_START, 0, 0, 0, 0, 0);
    send_frame(OP_RUN, 3000, 2500, 2000, 1000, 500);
    send_frame(OP_CLEAR, 0, 0, 0, 0, 0);
    send_frame(OP_START, 0, 0, 0, 0, 0);
    send_frame(OP_RUN, 4095, 4095, 4095, 4095, 4095);
    drain();

    run_phase(400);
    drain();

    write_cfg(REG_GAIN_P, 18'h07fff);
    write_cfg(REG_GAIN_I, 18'h08000);
    write_cfg(REG_GAIN_D, 18'h0ffff);
    write_cfg(REG_BASE_DUTY, 1023);
    write_cfg(REG_MAX_DUTY, 1023);
    write_cfg(REG_INT_LIMIT, 262143);
    write_cfg(REG_STOP_LVL, 65535);
    write_cfg(REG_LOST_LVL, 0);
    run_phase(300);
    drain();

    write_cfg(REG_GAIN_P, 18'h08000);
    write_cfg(REG_GAIN_I, 18'h07fff);
    write_cfg(REG_GAIN_D, 0);
    write_cfg(REG_BASE_DUTY, 0);
    write_cfg(REG_MAX_DUTY, 0);
    write_cfg(REG_INT_LIMIT, 0);
    write_cfg(REG_STOP_LVL, 0);
    write_cfg(REG_LOST_LVL, 65535);
    run_phase(200);
    drain();

    write_cfg(REG_GAIN_P, 18'($urandom_range(0, 65535)));
    write_cfg(REG_GAIN_I, 18'($urandom_range(0, 65535)));
    write_cfg(REG_GAIN_D, 18'($urandom_range(0, 65535)));
    write_cfg(REG_BASE_DUTY, 18'($urandom_range(0, 1023)));
    write_cfg(REG_MAX_DUTY, 18'($urandom_range(0, 1023)));
    write_cfg(REG_INT_LIMIT, 18'($urandom_range(0, 262143)));
    write_cfg(REG_STOP_LVL, 18'($urandom_range(30000, 65535)));
    write_cfg(REG_LOST_LVL, 18'($urandom_range(0, 30000)));
    hold_off = 400;
    stalls_on = 0;
    run_phase(20);
    stalls_on = 1;
    drain();

    write_cfg(REG_GAIN_P, 256);
    write_cfg(REG_GAIN_I, 16);
    write_cfg(REG_GAIN_D, 179);
    write_cfg(REG_BASE_DUTY, 500);
    write_cfg(REG_MAX_DUTY, 799);
    write_cfg(REG_INT_LIMIT, 128000);
    write_cfg(REG_STOP_LVL, 39322);
    write_cfg(REG_LOST_LVL, 19661);
    run_phase(650);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
